// ----- rtl/core/mss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mss_pkg
// Shared types and constants of the seven-segment scanner.
// ---------------------------------------------------------------------------
package mss_pkg;

    // Display size and field widths.
    localparam int DIGITS_MAX_DFLT = 8;
    localparam int NUM_W           = 27;
    localparam int WIDTH_W         = 4;
    localparam int ENABLES_W       = 8;
    localparam int SEG_W           = 8;
    localparam int BCD_DIGITS      = 9;
    localparam int CALC_W          = 5;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Configuration port.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_DIGITS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COMMON_ANODE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SEG_LOW      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEG_HIGH     = 2'd3;

    localparam logic [3:0] NUM_DIGITS_RST = 4'd8;

    // Segment levels of a blank display.
    localparam logic [SEG_W-1:0] BLANK_SEG_CATHODE = 8'h00;
    localparam logic [SEG_W-1:0] BLANK_SEG_ANODE   = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic shift;
        logic store;
        logic rewind;
        logic load_blank;
        logic load_show;
        logic advance;
    } scan_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/mss_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mss_datapath
// Binary to BCD shifter, digit store, configuration registers, scan
// position and the output item register.
// ---------------------------------------------------------------------------
module mss_datapath #(
    parameter int MAX_DIGITS = mss_pkg::DIGITS_MAX_DFLT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire mss_pkg::scan_cmd_t              cmd,
    input  wire logic [mss_pkg::NUM_W-1:0]       number,
    input  wire logic [mss_pkg::WIDTH_W-1:0]     width,
    input  wire logic                            cfg_we,
    input  wire logic [mss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [mss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic      [mss_pkg::ENABLES_W-1:0]   digit_enables,
    output logic      [mss_pkg::SEG_W-1:0]       segments,
    output logic                                 run_end
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int FP_W  = $clog2(MAX_DIGITS + 1);
    localparam int CW    = mss_pkg::CALC_W;
    localparam int BCD_W = 4 * mss_pkg::BCD_DIGITS;

    // Configuration registers.
    logic [3:0]  num_digits_reg;
    logic        common_anode_reg;
    logic [63:0] seg_low_reg;
    logic [15:0] seg_high_reg;

    // Conversion registers.
    logic [mss_pkg::NUM_W-1:0]   bin_reg;
    logic [BCD_W-1:0]            bcd_reg;
    logic [mss_pkg::WIDTH_W-1:0] wi_reg;

    // Display state.
    logic [3:0]      store_reg [MAX_DIGITS];
    logic [FP_W-1:0] fp_reg;
    logic [IDX_W-1:0] scan_reg;

    // Output item register.
    logic [mss_pkg::ENABLES_W-1:0] en_reg;
    logic [mss_pkg::SEG_W-1:0]     seg_reg;
    logic                          run_end_reg;

    // Wired digit count clamped to the display size.
    function automatic logic [FP_W-1:0] clamp_count(input logic [3:0] x);
        logic [FP_W-1:0] r;
        if (x == 4'd0) begin
            r = FP_W'(1);
        end else if (32'(x) > MAX_DIGITS) begin
            r = FP_W'(MAX_DIGITS);
        end else begin
            r = FP_W'(x);
        end
        return r;
    endfunction

    logic [FP_W-1:0] nd;
    logic [FP_W-1:0] nd_new;
    assign nd     = clamp_count(num_digits_reg);
    assign nd_new = clamp_count(cfg_wdata[3:0]);

    // Add-3 correction of every BCD digit before the shift.
    logic [BCD_W-1:0] bcd_adj;
    always_comb begin
        for (int j = 0; j < mss_pkg::BCD_DIGITS; j++) begin
            bcd_adj[4*j +: 4] = (bcd_reg[4*j +: 4] >= 4'd5) ?
                                bcd_reg[4*j +: 4] + 4'd3 : bcd_reg[4*j +: 4];
        end
    end

    // Leading digit: the value above the lower width-1 digits, saturated at 9.
    logic [3:0] bcd_dig [mss_pkg::BCD_DIGITS];
    logic [3:0] lead_pos;
    logic       upper_nz;
    logic [3:0] lead;
    always_comb begin
        for (int j = 0; j < mss_pkg::BCD_DIGITS; j++) begin
            bcd_dig[j] = bcd_reg[4*j +: 4];
        end
        lead_pos = wi_reg - 4'd1;
        upper_nz = 1'b0;
        for (int j = 0; j < mss_pkg::BCD_DIGITS; j++) begin
            if (4'(j) > lead_pos && bcd_dig[j] != 4'd0) begin
                upper_nz = 1'b1;
            end
        end
        if (32'(lead_pos) >= mss_pkg::BCD_DIGITS) begin
            lead = 4'd0;
        end else if (upper_nz) begin
            lead = 4'd9;
        end else begin
            lead = bcd_dig[lead_pos];
        end
    end

    // Store positions and fill position update.
    logic [CW-1:0]   fpx;
    logic [CW-1:0]   wix;
    logic [CW-1:0]   base;
    logic            lower_ok;
    logic [FP_W-1:0] fp_after;
    assign fpx      = CW'(fp_reg);
    assign wix      = CW'(wi_reg);
    assign base     = fpx - wix;
    assign lower_ok = (wi_reg > 4'd1) && (fpx >= wix);
    assign fp_after = (fpx > wix) ? FP_W'(base) : '0;

    // Scan position and the shown digit.
    logic [IDX_W-1:0] scan_eff;
    logic [IDX_W-1:0] scan_nxt;
    logic [3:0]       shown;
    logic [79:0]      seg_tbl;
    logic [7:0]       seg_raw;
    logic [mss_pkg::ENABLES_W-1:0] wired;
    logic [mss_pkg::ENABLES_W-1:0] scan_bit;
    logic [mss_pkg::ENABLES_W-1:0] blank_en;
    always_comb begin
        scan_eff = (FP_W'(scan_reg) >= nd) ? '0 : scan_reg;
        scan_nxt = (FP_W'(scan_eff) + FP_W'(1) >= nd) ? '0 : scan_eff + IDX_W'(1);
        shown    = store_reg[scan_eff];
        seg_tbl  = {seg_high_reg, seg_low_reg};
        seg_raw  = (shown < 4'd10) ? seg_tbl[{shown, 3'b000} +: 8] : 8'h00;
        for (int i = 0; i < mss_pkg::ENABLES_W; i++) begin
            wired[i] = (i < 32'(nd));
        end
        scan_bit = mss_pkg::ENABLES_W'(1) << scan_eff;
        blank_en = common_anode_reg ? '0 : wired;
    end

    // Configuration registers, written from the port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_digits_reg   <= mss_pkg::NUM_DIGITS_RST;
            common_anode_reg <= 1'b0;
            seg_low_reg      <= '0;
            seg_high_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mss_pkg::REG_NUM_DIGITS:   num_digits_reg   <= cfg_wdata[3:0];
                mss_pkg::REG_COMMON_ANODE: common_anode_reg <= cfg_wdata[0];
                mss_pkg::REG_SEG_LOW:      seg_low_reg      <= cfg_wdata[63:0];
                mss_pkg::REG_SEG_HIGH:     seg_high_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Shift-and-add-3 conversion, one input bit per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            bin_reg <= number;
            bcd_reg <= '0;
            wi_reg  <= (width == '0) ? mss_pkg::WIDTH_W'(1) : width;
        end else if (cmd.shift) begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[mss_pkg::NUM_W-1]};
            bin_reg <= {bin_reg[mss_pkg::NUM_W-2:0], 1'b0};
        end
    end

    // Digit store, fill position and scan position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < MAX_DIGITS; p++) begin
                store_reg[p] <= 4'd0;
            end
            fp_reg   <= clamp_count(mss_pkg::NUM_DIGITS_RST);
            scan_reg <= '0;
        end else begin
            if (cmd.store && fpx != '0) begin
                for (int p = 0; p < MAX_DIGITS; p++) begin
                    if (CW'(p) == fpx - CW'(1)) begin
                        store_reg[p] <= lead;
                    end else if (lower_ok && CW'(p) >= base && CW'(p) < fpx - CW'(1)) begin
                        store_reg[p] <= bcd_dig[4'(CW'(p) - base)];
                    end
                end
            end
            if (cfg_we && cfg_addr == mss_pkg::REG_NUM_DIGITS) begin
                fp_reg <= nd_new;
                if (FP_W'(scan_reg) >= nd_new) begin
                    scan_reg <= '0;
                end
            end else if (cmd.store) begin
                fp_reg <= cmd.rewind ? nd : fp_after;
            end
            if (cmd.advance) begin
                scan_reg <= scan_nxt;
            end
        end
    end

    // Output item register: blanking item, then the scanned digit.
    always_ff @(posedge aclk) begin
        if (cmd.load_blank) begin
            en_reg      <= blank_en;
            seg_reg     <= common_anode_reg ? mss_pkg::BLANK_SEG_ANODE
                                            : mss_pkg::BLANK_SEG_CATHODE;
            run_end_reg <= 1'b0;
        end else if (cmd.load_show) begin
            en_reg      <= common_anode_reg ? (blank_en | scan_bit) : (blank_en & ~scan_bit);
            seg_reg     <= common_anode_reg ? ~seg_raw : seg_raw;
            run_end_reg <= 1'b1;
        end
    end

    assign digit_enables = en_reg;
    assign segments      = seg_reg;
    assign run_end       = run_end_reg;

endmodule
`default_nettype wire

// ----- rtl/core/mss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mss_ctrl
// Sequencer: takes an item, runs the conversion, stores the digits and
// hands out the two result items of a refresh.
// ---------------------------------------------------------------------------
module mss_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output mss_pkg::scan_cmd_t      cmd
);

    localparam int CNT_W = $clog2(mss_pkg::NUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STORE,
        ST_BLANK,
        ST_SHOW
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    last_next  = s_tlast;
                    cnt_next   = CNT_W'(mss_pkg::NUM_W);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                cmd.rewind = last_reg;
                if (last_reg) begin
                    cmd.load_blank = 1'b1;
                    m_tvalid_next  = 1'b1;
                    state_next     = ST_BLANK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLANK: begin
                if (m_tready) begin
                    cmd.load_show = 1'b1;
                    state_next    = ST_SHOW;
                end
            end
            ST_SHOW: begin
                if (m_tready) begin
                    cmd.advance   = 1'b1;
                    m_tvalid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire

// ----- rtl/core/multiplexed_seven_segment_scanner_unit.sv -----
// Each item is converted by the bit-serial BCD shifter (one input bit per
// cycle) and then stored; an item marked last also loads the blanking item.
// A new item is taken only after the last one is stored and, for an item
// marked last, after both result items have been handed out.
// Reset (aresetn low, synchronous): eight digits, common cathode, blank
// segment table, digit store zero, scan position zero.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// multiplexed_seven_segment_scanner_unit
// Fills a decimal digit store from incoming numbers and emits one scan step
// of a multiplexed seven-segment display per refresh.
// ---------------------------------------------------------------------------
module multiplexed_seven_segment_scanner_unit #(
    parameter int MAX_DIGITS = mss_pkg::DIGITS_MAX_DFLT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input items.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mss_pkg::S_TDATA_W-1:0]       s_tdata,  // number[26:0], width[30:27]
    input  wire logic                                s_tlast,  // last_value
    // Result items.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [mss_pkg::M_TDATA_W-1:0]       m_tdata,  // digit_enables[7:0], segments[15:8]
    output logic                                     m_tlast,  // run_end
    // Configuration writes.
    input  wire logic                                cfg_we,
    input  wire logic [mss_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [mss_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    mss_pkg::scan_cmd_t              cmd;
    logic [mss_pkg::ENABLES_W-1:0]   digit_enables;
    logic [mss_pkg::SEG_W-1:0]       segments;

    // Sequencer.
    mss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Conversion, storage and output.
    mss_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .number        (s_tdata[mss_pkg::NUM_W-1:0]),
        .width         (s_tdata[mss_pkg::NUM_W +: mss_pkg::WIDTH_W]),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .digit_enables (digit_enables),
        .segments      (segments),
        .run_end       (m_tlast)
    );

    assign m_tdata = {segments, digit_enables};

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the seven-segment scanner against a cycle-free predictor of its
// digit store, fill position and scan position. Numbers stream in over the
// input channel with bursty pacing. Scan results are drained under a varying
// stall pattern and compared field by field in a scoreboard.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 600;

    // Conventional segment codes for the digits 0 to 9.
    localparam logic [63:0] STD_SEG_LOW  = 64'h077D6D664F5B063F;
    localparam logic [15:0] STD_SEG_HIGH = 16'h6F7F;

    typedef logic [mss_pkg::NUM_W-1:0]      number_t;
    typedef logic [mss_pkg::WIDTH_W-1:0]    width_t;
    typedef logic [mss_pkg::CFG_DATA_W-1:0] cfg_data_t;

    // Scoreboard: tracks the display state and holds the expected scan items.
    class scan_scoreboard;
        typedef struct packed {
            logic [mss_pkg::ENABLES_W-1:0] enables;
            logic [mss_pkg::SEG_W-1:0]     segments;
            logic                          run_end;
        } scan_result_t;

        logic [3:0]   num_digits;
        logic         common_anode;
        logic [63:0]  seg_low;
        logic [15:0]  seg_high;
        logic [3:0]   digit_store [mss_pkg::DIGITS_MAX_DFLT];
        int unsigned  fill_pos;
        int unsigned  scan_pos;
        scan_result_t expected_q [$];
        int           fail_count;

        function new();
            num_digits   = mss_pkg::NUM_DIGITS_RST;
            common_anode = 1'b0;
            seg_low      = '0;
            seg_high     = '0;
            foreach (digit_store[i]) digit_store[i] = '0;
            fill_pos     = wired();
            scan_pos     = 0;
            fail_count   = 0;
        endfunction

        // Number of digits actually scanned, clamped to the display size.
        function int unsigned wired();
            if (num_digits < 1) return 1;
            if (num_digits > mss_pkg::DIGITS_MAX_DFLT) return mss_pkg::DIGITS_MAX_DFLT;
            return num_digits;
        endfunction

        function logic [mss_pkg::SEG_W-1:0] segment_of(logic [3:0] d);
            if (d < 8) return seg_low[8*d +: 8];
            if (d < 10) return seg_high[8*(d-8) +: 8];
            return '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [mss_pkg::CFG_ADDR_W-1:0] addr,
                                logic [mss_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                mss_pkg::REG_NUM_DIGITS: begin
                    num_digits = data[3:0];
                    fill_pos   = wired();
                    if (scan_pos >= wired()) scan_pos = 0;
                end
                mss_pkg::REG_COMMON_ANODE: common_anode = data[0];
                mss_pkg::REG_SEG_LOW:      seg_low      = data;
                mss_pkg::REG_SEG_HIGH:     seg_high     = data[15:0];
                default: ;
            endcase
        endfunction

        // Stores one number and, on the last item of a refresh, predicts the
        // blanking item and the shown digit.
        function void note_item(logic [mss_pkg::NUM_W-1:0] number,
                                logic [mss_pkg::WIDTH_W-1:0] width_f, logic last);
            longint unsigned num;
            longint unsigned scale;
            longint unsigned lead;
            int unsigned     w;
            int unsigned     nd;
            int unsigned     scan;
            logic [7:0]      mask;
            logic [7:0]      blank_en;
            logic [7:0]      seg;
            scan_result_t    r;
            num = number;
            w   = (width_f == 0) ? 1 : width_f;
            // Values that find no room left are dropped.
            if (fill_pos >= 1 && fill_pos <= mss_pkg::DIGITS_MAX_DFLT) begin
                scale = 1;
                for (int i = 1; i < w; i++) scale *= 10;
                lead = num / scale;
                if (lead > 9) lead = 9;
                digit_store[fill_pos-1] = lead[3:0];
                // Lower digits only go in when the whole value fits.
                if (w > 1 && fill_pos >= w) begin
                    scale = 1;
                    for (int i = 0; i + 1 < w; i++) begin
                        digit_store[fill_pos-w+i] = 4'((num / scale) % 10);
                        scale *= 10;
                    end
                end
                fill_pos = (fill_pos > w) ? fill_pos - w : 0;
            end
            if (!last) return;

            nd       = wired();
            fill_pos = nd;
            mask     = 8'((1 << nd) - 1);
            scan     = (scan_pos >= nd) ? 0 : scan_pos;
            blank_en = common_anode ? 8'h00 : mask;

            r.enables  = blank_en;
            r.segments = common_anode ? mss_pkg::BLANK_SEG_ANODE : mss_pkg::BLANK_SEG_CATHODE;
            r.run_end  = 1'b0;
            expected_q.push_back(r);

            seg = segment_of(digit_store[scan]);
            if (common_anode) seg = ~seg;
            r.enables  = common_anode ? (blank_en | (8'h01 << scan))
                                      : (blank_en & ~(8'h01 << scan));
            r.segments = seg;
            r.run_end  = 1'b1;
            expected_q.push_back(r);

            scan++;
            scan_pos = (scan >= nd) ? 0 : scan;
        endfunction

        function void check_result(logic [mss_pkg::ENABLES_W-1:0] enables,
                                   logic [mss_pkg::SEG_W-1:0] segments, logic run_end);
            scan_result_t want;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] unexpected scan item: enables=%h segments=%h run_end=%b",
                             $realtime, enables, segments, run_end);
                return;
            end
            want = expected_q.pop_front();
            if (want.enables !== enables || want.segments !== segments
                    || want.run_end !== run_end) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] scan item differs: expected enables=%h segments=%h",
                             $realtime, want.enables, want.segments,
                             " run_end=%b, got enables=%h segments=%h run_end=%b",
                             want.run_end, enables, segments, run_end);
            end
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [mss_pkg::S_TDATA_W-1:0]     s_tdata;   // number[26:0], width[30:27]
    logic                              s_tlast;   // last_value
    logic                              m_tvalid;
    logic                              m_tready;
    logic [mss_pkg::M_TDATA_W-1:0]     m_tdata;   // digit_enables[7:0], segments[15:8]
    logic                              m_tlast;   // run_end
    logic                              cfg_we;
    logic [mss_pkg::CFG_ADDR_W-1:0]    cfg_addr;
    logic [mss_pkg::CFG_DATA_W-1:0]    cfg_wdata;

    scan_scoreboard board;
    int             items_accepted;
    int             items_offered;
    int             idle_cycles;
    int             burst_left;
    bit             use_gaps;

    multiplexed_seven_segment_scanner_unit #(
        .MAX_DIGITS(mss_pkg::DIGITS_MAX_DFLT)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // Observe every handshake and register write at the clock edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) board.write_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready) begin
                board.note_item(s_tdata[mss_pkg::NUM_W-1:0],
                                s_tdata[mss_pkg::NUM_W +: mss_pkg::WIDTH_W], s_tlast);
                items_accepted++;
            end
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[mss_pkg::ENABLES_W-1:0],
                                   m_tdata[mss_pkg::ENABLES_W +: mss_pkg::SEG_W], m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            // Nothing has moved for too long: the block is stuck.
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side stall pattern, with one long hold-off while items are offered.
    initial begin
        int mode;
        int mode_left;
        int tick;
        bit held;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        held      = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && !held && items_accepted >= HOLD_AFTER && s_tvalid) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (tick % 5 == 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Offers one item, opening a new burst after a random gap when needed.
    task automatic offer_item(input logic [mss_pkg::NUM_W-1:0] number,
                              input logic [mss_pkg::WIDTH_W-1:0] width_f,
                              input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = (!use_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        items_offered++;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, width_f, number};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg_port(input logic [mss_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [mss_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [3:0] digits, input logic anode,
                              input logic [63:0] low, input logic [15:0] high);
        write_reg_port(mss_pkg::REG_NUM_DIGITS, cfg_data_t'(digits));
        write_reg_port(mss_pkg::REG_COMMON_ANODE, cfg_data_t'(anode));
        write_reg_port(mss_pkg::REG_SEG_LOW, low);
        write_reg_port(mss_pkg::REG_SEG_HIGH, cfg_data_t'(high));
        cfg_we <= 1'b0;
    endtask

    // Stops offering and waits until every scan item is out and the block rests.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    // One well-formed refresh: widths that exactly fill the wired digits.
    task automatic send_refresh(input int digits);
        int          remaining;
        int          w;
        int unsigned top;
        number_t     number;
        remaining = digits;
        while (remaining > 0) begin
            w   = $urandom_range(1, remaining);
            top = 1;
            repeat (w) top *= 10;
            // Now and then a value too large for its width.
            number = ($urandom_range(0, 7) == 0) ? number_t'($urandom)
                                                  : number_t'($urandom_range(0, top - 1));
            remaining -= w;
            offer_item(number, width_t'(w), remaining == 0);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            offer_item(number_t'($urandom), width_t'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)));
    endtask

    // Stimulus sequence.
    initial begin
        logic [3:0]  phase_digits [PHASES];
        logic [63:0] low;
        logic [15:0] high;
        int          eff;
        int          target;
        phase_digits = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd5, 4'd2, 4'd7};
        board          = new();
        items_accepted = 0;
        items_offered  = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        use_gaps       = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // A scan with the reset settings and a blank segment table.
        offer_item(27'd0, 4'd1, 1'b1);
        settle();
        set_config(4'd8, 1'b0, STD_SEG_LOW, STD_SEG_HIGH);

        // Directed cases on eight digits, common cathode.
        offer_item(27'd12345678, 4'd8, 1'b1);
        // Store filled by this value, so the next one is ignored.
        offer_item(27'd87654321, 4'd8, 1'b0);
        offer_item(27'd5, 4'd1, 1'b1);
        offer_item(27'd99999999, 4'd8, 1'b1);
        // Oversized leading digit, zero width, then running out of room.
        offer_item(27'd123, 4'd1, 1'b0);
        offer_item(27'd7, 4'd0, 1'b0);
        offer_item(27'd45, 4'd2, 1'b0);
        offer_item(27'd9876, 4'd4, 1'b0);
        offer_item(27'd1, 4'd1, 1'b1);
        // Width beyond the display.
        offer_item(27'h7FFFFFF, 4'd15, 1'b1);
        // Largest number in eight digits saturates the leading digit.
        offer_item(27'h7FFFFFF, 4'd8, 1'b1);
        // Partial room: only the leading digit of the wide value fits.
        offer_item(27'd4567, 4'd3, 1'b0);
        offer_item(27'd98765, 4'd9, 1'b1);
        offer_item(27'd99999999, 4'd12, 1'b0);
        offer_item(27'd3, 4'd1, 1'b1);
        // Enough further scans to wrap the scan position.
        offer_item(27'd55555555, 4'd8, 1'b1);
        offer_item(27'd0, 4'd8, 1'b1);
        offer_item(27'd24681357, 4'd8, 1'b1);
        settle();

        // Random phases, each under its own display setting.
        for (int p = 0; p < PHASES; p++) begin
            low  = (p == 1) ? 64'h0 : (p == 2) ? '1 : {$urandom, $urandom};
            high = (p == 1) ? 16'h0 : (p == 2) ? '1 : 16'($urandom);
            set_config(phase_digits[p], 1'(p), low, high);
            eff = (phase_digits[p] == 0) ? 1
                : (phase_digits[p] > mss_pkg::DIGITS_MAX_DFLT) ? mss_pkg::DIGITS_MAX_DFLT
                : phase_digits[p];
            use_gaps = (p != 3);
            target   = items_offered + PHASE_ITEMS;
            while (items_offered < target) begin
                if ($urandom_range(0, 9) < 7) send_refresh(eff);
                else send_noise();
            end
            settle();
        end

        if (board.fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
